### hdl/brb_pkg.sv
package brb_pkg;

    localparam int BYTE_W     = 8;
    localparam int ACT_W      = 3;
    localparam int LEN_W      = 7;
    localparam int CAP_W      = 11;
    localparam int RUN_W      = 10;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 1;

    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 3'd0,
        ACT_READ  = 3'd1,
        ACT_PEEK  = 3'd2,
        ACT_SKIP  = 3'd3,
        ACT_CLEAR = 3'd4
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              byte_valid;
        logic              end_of_run;
        logic [RUN_W-1:0]  moved_total;
        logic [RUN_W-1:0]  used_after;
        logic [RUN_W-1:0]  free_after;
    } result_t;

endpackage

### hdl/brb_ram.sv
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/brb_out.sv
module brb_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  brb_pkg::result_t push_res,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output brb_pkg::result_t out_res
);

    import brb_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = push || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= push_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |-> !push)
        else $error("result pushed over a stalled item");

endmodule

### hdl/brb_ctrl.sv
module brb_ctrl #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [brb_pkg::ACT_W-1:0] in_action,
    input  logic [brb_pkg::BYTE_W-1:0] in_data,
    input  logic                      in_eow,
    input  logic [brb_pkg::LEN_W-1:0] in_length,
    input  logic                      cfg_we,
    input  logic [brb_pkg::CAP_W-1:0] cfg_wdata,
    input  logic                      out_free,
    output logic                      out_push,
    output brb_pkg::result_t          out_res,
    output logic                      mem_we,
    output logic [PTR_W-1:0]          mem_waddr,
    output logic [brb_pkg::BYTE_W-1:0] mem_wdata,
    output logic                      mem_re,
    output logic [PTR_W-1:0]          mem_raddr,
    input  logic [brb_pkg::BYTE_W-1:0] mem_rdata
);

    import brb_pkg::*;

    localparam int AW      = (PTR_W > CAP_W) ? PTR_W : CAP_W;
    localparam int CNT_W   = $clog2(MAX_BURST + 1);
    localparam int CAP_MAX = (DEPTH > 2047) ? 2047 : DEPTH;
    localparam int CAP_RST = (DEPTH < 1024) ? DEPTH : 1024;

    localparam logic [CAP_W-1:0] CAP_MAX_V = CAP_W'(CAP_MAX);
    localparam logic [CAP_W-1:0] CAP_RST_V = CAP_W'(CAP_RST);
    localparam logic [CAP_W-1:0] CAP_MIN_V = CAP_W'(2);
    localparam logic [LEN_W-1:0] BURST_V   = LEN_W'(MAX_BURST);

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [PTR_W-1:0]   p_reg, p_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CAP_W-1:0]   used0_reg, used0_next;
    logic               is_read_reg, is_read_next;

    action_t            act;
    logic               accept;
    logic [CAP_W-1:0]   used;
    logic [CAP_W-1:0]   free_now;
    logic [LEN_W-1:0]   len_c;
    logic [CNT_W-1:0]   n_c;
    logic [CNT_W-1:0]   cnt_inc;
    logic               run_last;
    logic [AW-1:0]      skip_sum;
    logic [RUN_W-1:0]   run_inc;
    logic               wr_ok;
    logic [CAP_W-1:0]   used_emit;

    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p,
                                                  input logic [CAP_W-1:0] cap);
        logic [AW-1:0] q;
        q = AW'(p) + AW'(1);
        return (q >= AW'(cap)) ? '0 : q[PTR_W-1:0];
    endfunction

    function automatic logic [CAP_W-1:0] held(input logic [PTR_W-1:0] wp,
                                              input logic [PTR_W-1:0] rp,
                                              input logic [CAP_W-1:0] cap);
        logic [AW-1:0] d;
        if (wp >= rp)
        begin
            d = AW'(wp) - AW'(rp);
        end
        else
        begin
            d = AW'(cap) - (AW'(rp) - AW'(wp));
        end
        return d[CAP_W-1:0];
    endfunction

    function automatic logic [RUN_W-1:0] free_of(input logic [CAP_W-1:0] u,
                                                 input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] f;
        f = cap - u - CAP_W'(1);
        return f[RUN_W-1:0];
    endfunction

    assign act      = action_t'(in_action);
    assign accept   = in_valid && in_ready;
    assign used     = held(wp_reg, rp_reg, cap_reg);
    assign free_now = cap_reg - used - CAP_W'(1);
    assign len_c    = (in_length > BURST_V) ? BURST_V : in_length;
    assign n_c      = (CAP_W'(len_c) < used) ? CNT_W'(len_c) : CNT_W'(used);
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign run_last = (cnt_inc == n_reg);
    assign skip_sum = AW'(rp_reg) + AW'(n_c);
    assign wr_ok    = (free_now != '0);
    assign run_inc  = (run_reg == RUN_MAX) ? run_reg : run_reg + RUN_W'(1);
    assign used_emit = is_read_reg ? (used0_reg - CAP_W'(cnt_inc)) : used0_reg;

    // state machine: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cfg_we && accept && (act == ACT_READ || act == ACT_PEEK)
                    && n_c != '0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && run_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state machine: outputs
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: in_ready = out_free;
            ST_EMIT: in_ready = 1'b0;
            default: in_ready = 1'b0;
        endcase
    end

    // pointers, memory access and results
    always_comb
    begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        p_next       = p_reg;
        run_next     = run_reg;
        cap_next     = cap_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        used0_next   = used0_reg;
        is_read_next = is_read_reg;
        out_push     = 1'b0;
        out_res      = '0;
        mem_we       = 1'b0;
        mem_waddr    = wp_reg;
        mem_wdata    = in_data;
        mem_re       = 1'b0;
        mem_raddr    = rp_reg;

        if (cfg_we)
        begin
            if (cfg_wdata < CAP_MIN_V)
            begin
                cap_next = CAP_MIN_V;
            end
            else if (cfg_wdata > CAP_MAX_V)
            begin
                cap_next = CAP_MAX_V;
            end
            else
            begin
                cap_next = cfg_wdata;
            end
            wp_next  = '0;
            rp_next  = '0;
            run_next = '0;
        end
        else if (state_reg == ST_IDLE)
        begin
            if (accept)
            begin
                unique case (act)
                    ACT_WRITE:
                    begin
                        out_push           = 1'b1;
                        out_res.end_of_run = 1'b1;
                        out_res.byte_valid = wr_ok;
                        if (wr_ok)
                        begin
                            mem_we              = 1'b1;
                            wp_next             = step_ptr(wp_reg, cap_reg);
                            out_res.moved_total = run_inc;
                            out_res.used_after  = RUN_W'(used + CAP_W'(1));
                            out_res.free_after  = free_of(used + CAP_W'(1), cap_reg);
                        end
                        else
                        begin
                            out_res.moved_total = run_reg;
                            out_res.used_after  = RUN_W'(used);
                            out_res.free_after  = free_of(used, cap_reg);
                        end
                        run_next = in_eow ? '0 : out_res.moved_total;
                    end
                    ACT_READ, ACT_PEEK:
                    begin
                        if (n_c == '0)
                        begin
                            out_push           = 1'b1;
                            out_res.end_of_run = 1'b1;
                            out_res.used_after = RUN_W'(used);
                            out_res.free_after = free_of(used, cap_reg);
                        end
                        else
                        begin
                            mem_re       = 1'b1;
                            mem_raddr    = rp_reg;
                            p_next       = rp_reg;
                            cnt_next     = '0;
                            n_next       = n_c;
                            used0_next   = used;
                            is_read_next = (act == ACT_READ);
                        end
                    end
                    ACT_SKIP:
                    begin
                        rp_next = (skip_sum >= AW'(cap_reg))
                                  ? PTR_W'(skip_sum - AW'(cap_reg))
                                  : PTR_W'(skip_sum);
                        out_push            = 1'b1;
                        out_res.end_of_run  = 1'b1;
                        out_res.moved_total = RUN_W'(n_c);
                        out_res.used_after  = RUN_W'(used - CAP_W'(n_c));
                        out_res.free_after  = free_of(used - CAP_W'(n_c), cap_reg);
                    end
                    ACT_CLEAR:
                    begin
                        wp_next            = '0;
                        rp_next            = '0;
                        run_next           = '0;
                        out_push           = 1'b1;
                        out_res.end_of_run = 1'b1;
                        out_res.free_after = free_of('0, cap_reg);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (out_free)
        begin
            out_push            = 1'b1;
            out_res.read_byte   = mem_rdata;
            out_res.byte_valid  = 1'b1;
            out_res.end_of_run  = run_last;
            out_res.moved_total = RUN_W'(cnt_inc);
            out_res.used_after  = RUN_W'(used_emit);
            out_res.free_after  = free_of(used_emit, cap_reg);
            p_next              = step_ptr(p_reg, cap_reg);
            cnt_next            = cnt_inc;
            if (is_read_reg)
            begin
                rp_next = p_next;
            end
            if (!run_last)
            begin
                mem_re    = 1'b1;
                mem_raddr = p_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            run_reg   <= '0;
            cap_reg   <= CAP_RST_V;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            run_reg   <= run_next;
            cap_reg   <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        cnt_reg     <= cnt_next;
        n_reg       <= n_next;
        used0_reg   <= used0_next;
        is_read_reg <= is_read_next;
    end

    a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> out_free)
        else $error("result pushed while output stage is full");

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (AW'(wp_reg) < AW'(cap_reg)) && (AW'(rp_reg) < AW'(cap_reg)))
        else $error("pointer beyond capacity");

    a_never_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        used < cap_reg)
        else $error("buffer holds capacity bytes");

    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (cnt_reg < n_reg))
        else $error("burst count past its length");

    a_no_write_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !mem_we)
        else $error("byte stored during a burst");

endmodule

### hdl/byte_ring_buffer.sv
// channel   direction  tdata (low bit up)                                 tuser       tlast
// s_axis    in         data_byte[7:0] length[14:8] zero[15]               action[2:0] end_of_write
// m_axis    out        read_byte[7:0] moved_total[17:8] used_after[27:18] byte_valid  end_of_run
//                      free_after[37:28] zero[39:38]
// cfg       in         cfg_wdata = capacity, written when cfg_we is high
//
// write, skip and clear items give one result each, pushed in the cycle they are accepted
// read and peek give one byte per cycle, unless a result waits on m_axis_tready, after a registered memory read
// the single read port of the byte memory sets the burst rate
// reset empties the buffer with capacity 1024 (or DEPTH if smaller); memory is not cleared
// input is held off during a burst and while a result waits on m_axis_tready
module byte_ring_buffer #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [brb_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // data_byte, length
    input  logic [brb_pkg::ACT_W-1:0]      s_axis_tuser,   // action
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [brb_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // read_byte, moved_total, used_after, free_after
    output logic [brb_pkg::OUT_USER_W-1:0] m_axis_tuser,   // byte_valid
    output logic                           m_axis_tlast,
    input  logic                           cfg_we,
    input  logic [brb_pkg::CAP_W-1:0]      cfg_wdata
);

    import brb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              out_free;
    logic              out_push;
    result_t           push_res;
    result_t           m_res;
    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [PTR_W-1:0]  mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    brb_ctrl #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_data   (s_axis_tdata[BYTE_W-1:0]),
        .in_eow    (s_axis_tlast),
        .in_length (s_axis_tdata[BYTE_W+LEN_W-1:BYTE_W]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_free  (out_free),
        .out_push  (out_push),
        .out_res   (push_res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    brb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    brb_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_res  (push_res),
        .free      (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (m_res)
    );

    assign m_axis_tdata = {2'b00, m_res.free_after, m_res.used_after,
                           m_res.moved_total, m_res.read_byte};
    assign m_axis_tuser = m_res.byte_valid;
    assign m_axis_tlast = m_res.end_of_run;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import brb_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int MAX_BURST   = 64;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 8;

    // action codes the block ignores
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    class ring_tracker;
        logic [BYTE_W-1:0] mem_bytes [DEPTH];
        int unsigned       wr_ptr;
        int unsigned       rd_ptr;
        int unsigned       run_total;
        int unsigned       capacity;
        result_t           due_results [$];
        int unsigned       errors;
        int unsigned       checked;

        function new();
            capacity = DEPTH;
            errors   = 0;
            checked  = 0;
            empty_ring();
        endfunction

        function void empty_ring();
            wr_ptr    = 0;
            rd_ptr    = 0;
            run_total = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            int unsigned v;
            v = 32'(value);
            if (v < 2)
                v = 2;
            if (v > DEPTH)
                v = DEPTH;
            capacity = v;
            empty_ring();
        endfunction

        function int unsigned held();
            if (wr_ptr >= rd_ptr)
                return wr_ptr - rd_ptr;
            return capacity - (rd_ptr - wr_ptr);
        endfunction

        function int unsigned advance(int unsigned p);
            p++;
            if (p >= capacity)
                p = 0;
            return p;
        endfunction

        function void queue_result(logic [BYTE_W-1:0] b, logic valid, logic last,
                                   int unsigned moved);
            result_t     r;
            int unsigned used;
            used         = held();
            r.read_byte   = b;
            r.byte_valid  = valid;
            r.end_of_run  = last;
            r.moved_total = moved[RUN_W-1:0];
            r.used_after  = used[RUN_W-1:0];
            r.free_after  = RUN_W'(capacity - used - 1);
            due_results.push_back(r);
        endfunction

        function void apply_item(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] data,
                                 logic eow, logic [LEN_W-1:0] len);
            int unsigned want;
            int unsigned n;
            int unsigned p;
            logic        ok;
            want = 32'(len);
            if (want > MAX_BURST)
                want = MAX_BURST;
            case (act)
                ACT_WRITE:
                begin
                    ok = 1'b0;
                    if (capacity - held() - 1 > 0)
                    begin
                        mem_bytes[PTR_W'(wr_ptr)] = data;
                        wr_ptr = advance(wr_ptr);
                        if (run_total < 32'(RUN_MAX))
                            run_total++;
                        ok = 1'b1;
                    end
                    queue_result('0, ok, 1'b1, run_total);
                    if (eow)
                        run_total = 0;
                end
                ACT_READ, ACT_PEEK:
                begin
                    n = (want < held()) ? want : held();
                    if (n == 0)
                        queue_result('0, 1'b0, 1'b1, 0);
                    else
                    begin
                        p = rd_ptr;
                        for (int unsigned k = 0; k < n; k++)
                        begin
                            logic [BYTE_W-1:0] b;
                            b = mem_bytes[PTR_W'(p)];
                            p = advance(p);
                            if (act == ACT_READ)
                                rd_ptr = p;
                            queue_result(b, 1'b1, k + 1 == n, k + 1);
                        end
                    end
                end
                ACT_SKIP:
                begin
                    n = (want < held()) ? want : held();
                    repeat (n)
                        rd_ptr = advance(rd_ptr);
                    queue_result('0, 1'b0, 1'b1, n);
                end
                ACT_CLEAR:
                begin
                    empty_ring();
                    queue_result('0, 1'b0, 1'b1, 0);
                end
                default:
                    ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                $error("result with nothing pending: read_byte %0d moved_total %0d",
                       got.read_byte, got.moved_total);
                errors++;
                return;
            end
            want = due_results.pop_front();
            checked++;
            compare_field("read_byte", 32'(want.read_byte), 32'(got.read_byte));
            compare_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
            compare_field("end_of_run", 32'(want.end_of_run), 32'(got.end_of_run));
            compare_field("moved_total", 32'(want.moved_total), 32'(got.moved_total));
            compare_field("used_after", 32'(want.used_after), 32'(got.used_after));
            compare_field("free_after", 32'(want.free_after), 32'(got.free_after));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [ACT_W-1:0]      s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [CAP_W-1:0]      cfg_wdata;

    ring_tracker tracker = new();
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycles         = 0;
    int unsigned items_sent     = 0;
    int unsigned cap_writes     = 0;

    byte_ring_buffer #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** byte_ring_buffer: FAILED **");
            $finish;
        end
    end

    // result side: check at the edge, then pick the next stall
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.read_byte   = m_axis_tdata[7:0];
            got.moved_total = m_axis_tdata[17:8];
            got.used_after  = m_axis_tdata[27:18];
            got.free_after  = m_axis_tdata[37:28];
            got.byte_valid  = m_axis_tuser[0];
            got.end_of_run  = m_axis_tlast;
            tracker.match_result(got);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] data, logic eow,
                             logic [LEN_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, len, data};
        s_axis_tuser  <= act;
        s_axis_tlast  <= eow;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.apply_item(act, data, eow, len);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.set_capacity(value);
        cap_writes++;
    endtask

    task automatic random_items(int unsigned count);
        int unsigned done;
        int unsigned r;
        int unsigned top;
        int unsigned burst;
        done = 0;
        while (done < count)
        begin
            r   = $urandom_range(99);
            top = tracker.capacity + 2;
            if (top > 127)
                top = 127;
            if (r < 45)
            begin
                // one write call of random bytes
                burst = $urandom_range((top > 24) ? 24 : top, 1);
                for (int unsigned i = 0; i < burst; i++)
                    send_item(ACT_WRITE, BYTE_W'($urandom),
                              (i + 1 == burst) ? ($urandom_range(3) != 0)
                              : ($urandom_range(15) == 0), LEN_W'($urandom));
                done += burst;
            end
            else
            begin
                if (r < 63)
                    send_item(ACT_READ, BYTE_W'($urandom), 1'($urandom),
                              LEN_W'($urandom_range(top)));
                else if (r < 76)
                    send_item(ACT_PEEK, BYTE_W'($urandom), 1'($urandom),
                              LEN_W'($urandom_range(top)));
                else if (r < 86)
                    send_item(ACT_SKIP, BYTE_W'($urandom), 1'($urandom),
                              LEN_W'($urandom_range(top)));
                else if (r < 91)
                    send_item(ACT_CLEAR, BYTE_W'($urandom), 1'($urandom),
                              LEN_W'($urandom));
                else if (r < 96)
                    send_item(ACT_W'($urandom_range(ACT_PEEK, ACT_READ)), BYTE_W'($urandom),
                              1'($urandom), LEN_W'($urandom_range(127)));
                else
                    send_item(ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)),
                              BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
                if (r < 96)
                    done++;
            end
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_WRITE;
        s_axis_tlast  <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 17;
        recv_stall_pct = 66;

        // empty buffer, small run, clamped lengths and ignored codes
        send_item(ACT_READ, 8'h00, 1'b0, 7'd5);
        send_item(ACT_PEEK, 8'h00, 1'b0, 7'd0);
        send_item(ACT_SKIP, 8'h00, 1'b0, 7'd3);
        send_item(ACT_WRITE, 8'h00, 1'b0, 7'd0);
        send_item(ACT_WRITE, 8'hFF, 1'b0, 7'd127);
        send_item(ACT_WRITE, 8'hA5, 1'b1, 7'd0);
        send_item(ACT_PEEK, 8'h00, 1'b0, 7'd0);
        send_item(ACT_PEEK, 8'h00, 1'b0, 7'd127);
        send_item(ACT_READ, 8'h00, 1'b0, 7'd2);
        for (int unsigned a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
            send_item(ACT_W'(a), 8'hFF, 1'b1, 7'd127);
        send_item(ACT_SKIP, 8'h00, 1'b0, 7'd64);
        send_item(ACT_WRITE, 8'h11, 1'b1, 7'd0);
        send_item(ACT_CLEAR, 8'h00, 1'b0, 7'd0);

        // smallest ring: one byte fits, the next is dropped
        write_capacity(11'd0);
        send_item(ACT_WRITE, 8'h5A, 1'b0, 7'd0);
        send_item(ACT_WRITE, 8'h3C, 1'b1, 7'd0);
        send_item(ACT_READ, 8'h00, 1'b0, 7'd1);

        write_capacity(11'd4);
        for (int unsigned i = 0; i < 5; i++)
            send_item(ACT_WRITE, 8'h80 | BYTE_W'(i), i == 4, 7'd0);
        send_item(ACT_SKIP, 8'h00, 1'b0, 7'd1);
        send_item(ACT_PEEK, 8'h00, 1'b0, 7'd64);
        send_item(ACT_READ, 8'h00, 1'b0, 7'd64);

        write_capacity(CAP_W'($urandom_range(12, 2)));
        random_items(120);

        send_idle_pct  = 66;
        recv_stall_pct = 17;
        write_capacity(11'h7FF);
        random_items(60);
        write_capacity(CAP_W'($urandom_range(64, 13)));
        random_items(60);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_capacity(11'd1);
        random_items(30);

        // one long write call: fill, overflow, then keep counting after a read
        write_capacity(11'd40);
        for (int unsigned i = 0; i < 45; i++)
            send_item(ACT_WRITE, BYTE_W'($urandom), 1'b0, LEN_W'($urandom));
        send_item(ACT_READ, 8'h00, 1'b0, 7'd64);
        for (int unsigned i = 0; i < 10; i++)
            send_item(ACT_WRITE, BYTE_W'($urandom), i == 9, LEN_W'($urandom));
        send_item(ACT_CLEAR, 8'h00, 1'b0, 7'd0);

        write_capacity(CAP_W'($urandom_range(300, 65)));
        random_items(70);

        drain();
        $display("run covered %0d items and %0d checked results over %0d capacity writes",
                 items_sent, tracker.checked, cap_writes);
        $display("reads, peeks, skips, clears and writes with wrap, overflow and clamped lengths");
        if (tracker.errors == 0)
            $display("** byte_ring_buffer: PASSED **");
        else
            $display("** byte_ring_buffer: FAILED **");
        $finish;
    end

endmodule
